@@ hw/rtl/rubi_pkg.sv @@
`timescale 1ns / 1ps

package rubi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int NUM_AXES  = 3;
   localparam int NUM_CAND  = 2 * NUM_AXES;
   // numerator |plane - origin| << FRAC_BITS
   localparam int NUM_W     = WORD_W + 1 + FRAC_BITS;
   localparam int REM_W     = WORD_W + 1;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int POS_W     = PROD_W - FRAC_BITS + 1;

   localparam logic signed [WORD_W:0]    ONE_EXT = (WORD_W + 1)'(1) << FRAC_BITS;
   localparam logic signed [POS_W-1:0]   ONE_POS = POS_W'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][WORD_W-1:0] org;
      logic [NUM_AXES-1:0][WORD_W-1:0] dir;
      logic [WORD_W-1:0]               t_near;
      logic [WORD_W-1:0]               t_far;
   } ray_type;

   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [WORD_W-1:0] den;
      logic [REM_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
      logic              neg;
      logic              live;
   } lane_type;

endpackage

@@ hw/rtl/ray_unit_box_intersect.sv @@
`timescale 1ns / 1ps
// Ray against the unit cube [-1,+1]^3, Q16.16 fixed point.
// Throughput: one transaction per cycle while the output is not stalled; the restoring dividers
// give one quotient bit per stage, six lanes side by side (one per face plane).
// Reset: synchronous, active high; clears only the stage valid bits.

module ray_unit_box_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_t_near_limit,
   input  logic signed [31:0] req_t_far_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_hit_distance,
   output logic [1:0]         rsp_face_axis,
   output logic               rsp_face_positive
);

   localparam int D  = rubi_pkg::NUM_W;
   localparam int NC = rubi_pkg::NUM_CAND;
   localparam int NA = rubi_pkg::NUM_AXES;
   localparam int W  = rubi_pkg::WORD_W;

   // One global advance: the whole pipe moves when the output slot is free or being taken.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // restoring divide, one quotient bit
   function automatic rubi_pkg::lane_type div_step(input rubi_pkg::lane_type l);
      rubi_pkg::lane_type          o;
      logic [rubi_pkg::REM_W-1:0]  r;
      logic                        ge;
      o  = l;
      r  = {l.rem[rubi_pkg::REM_W-2:0], l.num[D-1]};
      ge = (r >= {1'b0, l.den});
      o.num = l.num << 1;
      o.quo = {l.quo[D-2:0], ge};
      o.rem = ge ? (r - {1'b0, l.den}) : r;
      return o;
   endfunction

   // ---------------- input decode (stage 0) ----------------
   rubi_pkg::ray_type  ray_in;
   rubi_pkg::lane_type lane_in [NC];

   assign ray_in.org    = {req_origin_z, req_origin_y, req_origin_x};
   assign ray_in.dir    = {req_dir_z, req_dir_y, req_dir_x};
   assign ray_in.t_near = req_t_near_limit;
   assign ray_in.t_far  = req_t_far_limit;

   logic signed [W:0] n_in   [NC];
   logic [W:0]        mag_in [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         n_in[c] = (c[0] ? rubi_pkg::ONE_EXT : -rubi_pkg::ONE_EXT)
                   - {ray_in.org[c>>1][W-1], ray_in.org[c>>1]};
         mag_in[c] = n_in[c][W] ? (W+1)'(0) - n_in[c] : n_in[c];
         lane_in[c].num  = {mag_in[c], {rubi_pkg::FRAC_BITS{1'b0}}};
         lane_in[c].den  = ray_in.dir[c>>1][W-1] ? W'(0) - ray_in.dir[c>>1]
                                                 : ray_in.dir[c>>1];
         lane_in[c].rem  = '0;
         lane_in[c].quo  = '0;
         lane_in[c].neg  = n_in[c][W] ^ ray_in.dir[c>>1][W-1];
         lane_in[c].live = (ray_in.dir[c>>1] != '0);
      end
   end

   // ---------------- divider pipe ----------------
   logic [D:0]         vld_ff;
   rubi_pkg::ray_type  ray_ff  [D+1];
   rubi_pkg::lane_type lane_ff [D+1][NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[D-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray_ff[0] <= ray_in;
         for (int c = 0; c < NC; c++) lane_ff[0][c] <= lane_in[c];
         for (int s = 0; s < D; s++) begin
            ray_ff[s+1] <= ray_ff[s];
            for (int c = 0; c < NC; c++) lane_ff[s+1][c] <= div_step(lane_ff[s][c]);
         end
      end
   end

   // ---------------- saturate and range test ----------------
   logic               vld_t_ff;
   rubi_pkg::ray_type  ray_t_ff;
   logic signed [W-1:0] t_in   [NC];
   logic signed [W-1:0] t_t_ff [NC];
   logic [NC-1:0]      ok_in, ok_t_ff;
   logic [D-1:0]       q_mag [NC];
   logic               q_big [NC];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         q_mag[c] = lane_ff[D][c].quo;
         if (lane_ff[D][c].neg) begin
            // beyond 2^31 clamps to the most negative value
            q_big[c] = (|q_mag[c][D-1:W]) || (q_mag[c][W-1] && (|q_mag[c][W-2:0]));
            t_in[c]  = q_big[c] ? {1'b1, {(W-1){1'b0}}} : W'(0) - q_mag[c][W-1:0];
         end else begin
            q_big[c] = (|q_mag[c][D-1:W-1]);
            t_in[c]  = q_big[c] ? {1'b0, {(W-1){1'b1}}} : q_mag[c][W-1:0];
         end
         ok_in[c] = lane_ff[D][c].live
                    && ($signed(ray_ff[D].t_near) < t_in[c])
                    && (t_in[c] < $signed(ray_ff[D].t_far));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_t_ff <= 1'b0;
      end else if (advance) begin
         vld_t_ff <= vld_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray_t_ff <= ray_ff[D];
         ok_t_ff  <= ok_in;
         for (int c = 0; c < NC; c++) t_t_ff[c] <= t_in[c];
      end
   end

   // ---------------- products on the two other axes ----------------
   logic                    vld_p_ff;
   logic [NA-1:0][W-1:0]    org_p_ff;
   logic signed [W-1:0]     t_p_ff [NC];
   logic [NC-1:0]           ok_p_ff;
   logic signed [rubi_pkg::PROD_W-1:0] prod_in [NC][2];
   logic signed [rubi_pkg::PROD_W-1:0] prod_ff [NC][2];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         prod_in[c][0] = $signed(ray_t_ff.dir[((c>>1) == 2) ? 0 : (c>>1) + 1]) * t_t_ff[c];
         prod_in[c][1] = $signed(ray_t_ff.dir[((c>>1) == 0) ? 2 : (c>>1) - 1]) * t_t_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else if (advance) begin
         vld_p_ff <= vld_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         org_p_ff <= ray_t_ff.org;
         ok_p_ff  <= ok_t_ff;
         for (int c = 0; c < NC; c++) begin
            t_p_ff[c]     <= t_t_ff[c];
            prod_ff[c][0] <= prod_in[c][0];
            prod_ff[c][1] <= prod_in[c][1];
         end
      end
   end

   // ---------------- inside test ----------------
   logic                vld_c_ff;
   logic signed [W-1:0] t_c_ff [NC];
   logic [NC-1:0]       ok_c_in, ok_c_ff;
   logic signed [rubi_pkg::POS_W-1:0] pos_in [NC][2];

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         // floor division by ONE is the arithmetic shift
         pos_in[c][0] = rubi_pkg::POS_W'($signed(org_p_ff[((c>>1) == 2) ? 0 : (c>>1) + 1]))
                      + rubi_pkg::POS_W'(prod_ff[c][0] >>> rubi_pkg::FRAC_BITS);
         pos_in[c][1] = rubi_pkg::POS_W'($signed(org_p_ff[((c>>1) == 0) ? 2 : (c>>1) - 1]))
                      + rubi_pkg::POS_W'(prod_ff[c][1] >>> rubi_pkg::FRAC_BITS);
         ok_c_in[c] = ok_p_ff[c]
                      && (pos_in[c][0] <= rubi_pkg::ONE_POS)
                      && (pos_in[c][0] >= -rubi_pkg::ONE_POS)
                      && (pos_in[c][1] <= rubi_pkg::ONE_POS)
                      && (pos_in[c][1] >= -rubi_pkg::ONE_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (advance) begin
         vld_c_ff <= vld_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_c_ff <= ok_c_in;
         for (int c = 0; c < NC; c++) t_c_ff[c] <= t_p_ff[c];
      end
   end

   // ---------------- nearest per axis; plus face wins only if strictly nearer ----------------
   logic                vld_a_ff;
   logic [NA-1:0]       ax_ok_in, ax_ok_ff, ax_side_in, ax_side_ff;
   logic signed [W-1:0] ax_t_in [NA];
   logic signed [W-1:0] ax_t_ff [NA];

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         ax_side_in[a] = ok_c_ff[2*a+1] && (!ok_c_ff[2*a] || (t_c_ff[2*a+1] < t_c_ff[2*a]));
         ax_ok_in[a]   = ok_c_ff[2*a] || ok_c_ff[2*a+1];
         ax_t_in[a]    = ax_side_in[a] ? t_c_ff[2*a+1] : t_c_ff[2*a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (advance) begin
         vld_a_ff <= vld_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ok_ff   <= ax_ok_in;
         ax_side_ff <= ax_side_in;
         for (int a = 0; a < NA; a++) ax_t_ff[a] <= ax_t_in[a];
      end
   end

   // ---------------- across axes, x then y then z ----------------
   logic                rsp_valid_ff, rsp_hit_ff, rsp_pos_ff;
   logic                rsp_hit_in, rsp_pos_in;
   logic signed [W-1:0] rsp_dist_ff, rsp_dist_in, best_t;
   logic [1:0]          rsp_axis_ff, rsp_axis_in;
   logic                found;
   logic                best_side;
   rubi_pkg::axis_type  best_axis;

   always_comb begin
      found     = ax_ok_ff[0];
      best_t    = ax_t_ff[0];
      best_side = ax_side_ff[0];
      best_axis = rubi_pkg::AXIS_X;
      if (ax_ok_ff[1] && (!found || (ax_t_ff[1] < best_t))) begin
         found     = 1'b1;
         best_t    = ax_t_ff[1];
         best_side = ax_side_ff[1];
         best_axis = rubi_pkg::AXIS_Y;
      end
      if (ax_ok_ff[2] && (!found || (ax_t_ff[2] < best_t))) begin
         found     = 1'b1;
         best_t    = ax_t_ff[2];
         best_side = ax_side_ff[2];
         best_axis = rubi_pkg::AXIS_Z;
      end
      rsp_hit_in  = found;
      rsp_dist_in = found ? best_t : '0;
      rsp_axis_in = found ? best_axis : rubi_pkg::AXIS_X;
      rsp_pos_in  = found && best_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_dist_ff <= rsp_dist_in;
         rsp_axis_ff <= rsp_axis_in;
         rsp_pos_ff  <= rsp_pos_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_hit_distance  = rsp_dist_ff;
   assign rsp_face_axis     = rsp_axis_ff;
   assign rsp_face_positive = rsp_pos_ff;

endmodule

@@ verif/rubi_checker.sv @@
`timescale 1ns / 1ps

module rubi_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_t_near_limit,
   input  logic signed [31:0] req_t_far_limit,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_hit_distance,
   input  logic [1:0]         rsp_face_axis,
   input  logic               rsp_face_positive,
   output int                 fail_count,
   output int                 pending
);

   typedef struct {
      logic               hit;
      logic signed [31:0] distance;
      rubi_pkg::axis_type axis;
      logic               positive;
   } box_hit_type;

   box_hit_type hits_due[$];

   initial fail_count = 0;
   initial pending = 0;

   // nearest face crossing of the unit cube; ties keep the earlier face
   function automatic box_hit_type nearest_face(input logic signed [31:0] o [3],
                                                input logic signed [31:0] d [3],
                                                input logic signed [31:0] near_lim,
                                                input logic signed [31:0] far_lim);
      box_hit_type best;
      longint      one;
      longint      plane;
      longint      t;
      longint      p;
      bit          ok;
      int          k;
      one  = longint'(1) << rubi_pkg::FRAC_BITS;
      best = '{hit: 1'b0, distance: '0, axis: rubi_pkg::AXIS_X, positive: 1'b0};
      for (int i = 0; i < rubi_pkg::NUM_AXES; i++) begin
         if (d[i] == 0) continue;
         for (int s = 0; s < 2; s++) begin
            plane = s ? one : -one;
            t = ((plane - longint'(o[i])) * one) / longint'(d[i]);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            ok = (longint'(near_lim) < t) && (t < longint'(far_lim));
            for (int j = 1; j < 3; j++) begin
               k = (i + j) % 3;
               p = longint'(o[k]) + ((longint'(d[k]) * t) >>> rubi_pkg::FRAC_BITS);
               if (p > one || p < -one) ok = 0;
            end
            if (ok && (!best.hit || t < longint'(best.distance))) begin
               best.hit      = 1'b1;
               best.distance = t[31:0];
               best.axis     = rubi_pkg::axis_type'(i);
               best.positive = s[0];
            end
         end
      end
      return best;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      logic signed [31:0] o [3];
      logic signed [31:0] d [3];
      box_hit_type        want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            o = '{req_origin_x, req_origin_y, req_origin_z};
            d = '{req_dir_x, req_dir_y, req_dir_z};
            hits_due.push_back(nearest_face(o, d, req_t_near_limit, req_t_far_limit));
         end
         if (rsp_valid && !rsp_stall) begin
            if (hits_due.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = hits_due.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_hit_distance !== want.distance)
                  report_mismatch("hit_distance", rsp_hit_distance, want.distance);
               if (rsp_face_axis !== want.axis)
                  report_mismatch("face_axis", rsp_face_axis, want.axis);
               if (rsp_face_positive !== want.positive)
                  report_mismatch("face_positive", rsp_face_positive, want.positive);
            end
         end
      end
      pending = hits_due.size();
   end

endmodule

@@ verif/tb_ray_unit_box_intersect.sv @@
`timescale 1ns / 1ps

module tb_ray_unit_box_intersect;

   localparam int ONE        = 1 << rubi_pkg::FRAC_BITS;
   localparam int NUM_RANDOM = 1350;
   localparam int IDLE_LIMIT = 3000;   // cycles with no transaction on either side

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic signed [31:0] req_t_near_limit, req_t_far_limit;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_hit;
   logic signed [31:0] rsp_hit_distance;
   logic [1:0]         rsp_face_axis;
   logic               rsp_face_positive;
   int                 fail_count;
   int                 pending;
   bit                 steady;     // no idling on either side while set
   int                 idle_cycles;

   ray_unit_box_intersect dut (.*);

   rubi_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // random gap length: mostly none or short, occasionally long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // watchdog: ends the run if both channels sit still for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ray_unit_box_intersect verification failed");
         $finish;
      end
   end

   // one transaction on the request side, held until accepted
   task automatic send_ray(input int ox, oy, oz, dx, dy, dz, tn, tf);
      bit taken;
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_origin_x     <= ox;
      req_origin_y     <= oy;
      req_origin_z     <= oz;
      req_dir_x        <= dx;
      req_dir_y        <= dy;
      req_dir_z        <= dz;
      req_t_near_limit <= tn;
      req_t_far_limit  <= tf;
      do begin
         @(posedge clock);
         taken = req_valid && !req_stall;
         @(negedge clock);
      end while (!taken);
   endtask

   // a ray aimed at a random point of the cube, so most of these hit
   task automatic send_aimed_ray();
      int o [3];
      int d [3];
      int tn, tf;
      int sh;
      sh = $urandom_range(0, 5);
      for (int a = 0; a < 3; a++) begin
         o[a] = int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
         d[a] = int'($urandom_range(0, 2 * ONE)) - ONE - o[a];
         // rescale: long and short directions, both signs of t
         d[a] = (sh < 3) ? (d[a] >>> sh) : (d[a] <<< (sh - 3));
         if ($urandom_range(0, 9) == 0) d[a] = 0;
         if ($urandom_range(0, 15) == 0) d[a] = -d[a];
      end
      case ($urandom_range(0, 3))
         0: begin tn = 0; tf = 32'sh7fffffff; end
         1: begin tn = -int'($urandom_range(0, 4 * ONE)); tf = $urandom_range(0, 8 * ONE); end
         2: begin tn = $urandom_range(0, 2 * ONE); tf = tn + int'($urandom_range(0, 4 * ONE)); end
         default: begin tn = 32'sh80000000; tf = 32'sh7fffffff; end
      endcase
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2], tn, tf);
   endtask

   initial begin
      int r;
      reset            = 1'b1;
      steady           = 1'b1;
      req_valid        = 1'b0;
      req_origin_x     = '0;
      req_origin_y     = '0;
      req_origin_z     = '0;
      req_dir_x        = '0;
      req_dir_y        = '0;
      req_dir_z        = '0;
      req_t_near_limit = '0;
      req_t_far_limit  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: a straight hit along each axis from both sides
      send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 0, 32'sh7fffffff);
      send_ray(3 * ONE, 0, 0, -ONE, 0, 0, 0, 32'sh7fffffff);
      send_ray(0, -3 * ONE, 0, 0, ONE, 0, 0, 32'sh7fffffff);
      send_ray(0, 3 * ONE, 0, 0, -ONE, 0, 0, 32'sh7fffffff);
      send_ray(0, 0, -3 * ONE, 0, 0, ONE, 0, 32'sh7fffffff);
      send_ray(0, 0, 3 * ONE, 0, 0, -ONE, 0, 32'sh7fffffff);
      // origin inside: the near face lies behind, only caught with a negative near limit
      send_ray(0, 0, 0, ONE, ONE / 2, ONE / 4, 32'sh80000000, 32'sh7fffffff);
      send_ray(0, 0, 0, ONE, ONE / 2, ONE / 4, 0, 32'sh7fffffff);
      // tie on an edge: x and y faces at the same distance, x is kept
      send_ray(-3 * ONE, -3 * ONE, 0, ONE, ONE, 0, 0, 32'sh7fffffff);
      // grazing the edge exactly, inclusive bound
      send_ray(-3 * ONE, ONE, 0, ONE, 0, 0, 0, 32'sh7fffffff);
      send_ray(-3 * ONE, ONE + 1, 0, ONE, 0, 0, 0, 32'sh7fffffff);
      // zero direction on every axis
      send_ray(0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff);
      // empty and inverted limits
      send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 5 * ONE, 5 * ONE);
      send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 8 * ONE, ONE);
      // distance limits strictly exclusive at the hit distance
      send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 2 * ONE, 5 * ONE);
      send_ray(-3 * ONE, 0, 0, ONE, 0, 0, 0, 2 * ONE);
      // tiny direction: distance saturates; then the most negative direction, distance near zero
      send_ray(-3 * ONE, 0, 0, 1, 0, 0, 32'sh80000000, 32'sh7fffffff);
      send_ray(3 * ONE, 0, 0, 32'sh80000000, 0, 0, 32'sh80000000, 32'sh7fffffff);
      // field extremes
      send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7fffffff);
      send_ray(-1, -1, -1, -1, -1, -1, -1, -1);

      steady = 1'b0;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         // a stretch with no idling partway through
         steady = (i >= 500 && i < 650);
         r = $urandom_range(0, 99);
         if (r < 75)
            send_aimed_ray();
         else if (r < 90)
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
         else
            // small random values near the cube, limits anywhere
            send_ray(int'($urandom_range(0, 6 * ONE)) - 3 * ONE,
                     int'($urandom_range(0, 6 * ONE)) - 3 * ONE,
                     int'($urandom_range(0, 6 * ONE)) - 3 * ONE,
                     int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 4)) - 2,
                     int'($urandom_range(0, 2 * ONE)) - ONE, $urandom, $urandom);
      end
      req_valid <= 1'b0;

      // drain, then allow the pipeline depth for anything stray
      while (pending != 0) @(posedge clock);
      repeat (rubi_pkg::NUM_W + 20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ray_unit_box_intersect verification clean");
      else
         $display("ray_unit_box_intersect verification failed");
      $finish;
   end

endmodule
